@@ rtl/core/mmsr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmsr_pkg
// Shared sizes, codes, command/status bundles and helpers for the
// multi-mode signal reduction block.
// ----------------------------------------------------------------------------
`default_nettype none

package mmsr_pkg;

  // Capacity of one set and derived widths
  localparam int MAX_SIGNALS = 16;
  localparam int IDX_W  = (MAX_SIGNALS > 1) ? $clog2(MAX_SIGNALS) : 1;
  localparam int CNT_W  = $clog2(MAX_SIGNALS + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int NUM_W  = SUM_W + 16;
  localparam int DEN_W  = SUM_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  // y^n with y below 2^31 fits in one 32-bit limb per signal
  localparam int LIMBS  = MAX_SIGNALS;

  // Reduction modes
  localparam logic [2:0] MODE_HILL = 3'd0;
  localparam logic [2:0] MODE_SUM  = 3'd1;
  localparam logic [2:0] MODE_PROD = 3'd2;
  localparam logic [2:0] MODE_MEAN = 3'd3;
  localparam logic [2:0] MODE_MAX  = 3'd4;
  localparam logic [2:0] MODE_MIN  = 3'd5;
  localparam logic [2:0] MODE_MED  = 3'd6;
  localparam logic [2:0] MODE_GEO  = 3'd7;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;
  localparam logic [1:0] ST_DROP  = 2'd3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE   = 32'sh00010000;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic prod;
    logic fin;
    logic div_step;
    logic div_end;
    logic med_cand;
    logic med_load;
    logic med_step;
    logic med_eval;
    logic med_fin;
    logic gm_try;
    logic gm_mul;
    logic gm_cmp;
    logic gm_next;
    logic emit;
  } mmsr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       last_item;
    logic       empty;
    logic [2:0] mode;
    logic       hill_undef;
    logic       geo_undef;
    logic       div_last;
    logic       scan_last;
    logic       i_last;
    logic       pass_zero;
    logic       limb_last;
    logic       bit_zero;
    logic       out_free;
  } mmsr_sts_t;

  // Saturate to 32 bits; bit 32 flags saturation
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b1, S32_MAX};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, S32_MIN};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/multi_mode_signal_reduction.sv @@
// ----------------------------------------------------------------------------
// multi_mode_signal_reduction
// Reduces a set of Q16.16 signals to one value in the selected mode.
// ----------------------------------------------------------------------------
// Each signal is stored, then a running product step follows in which no
// signal is taken. After the last signal, sum/prod/max/min go straight to the
// result, hill/mean run a bit-serial divider, median a rank scan on the
// single-read store and geometric mean a limb-serial 32x32 multiplier. The result waits in an
// output register. Reset clears the set state and sets reduce_mode to 0.
`default_nettype none

module multi_mode_signal_reduction import mmsr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] signal_value,
  input  wire logic               last_signal,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      reduced_value,
  output logic [1:0]              status
);

  localparam logic REG_MODE = 1'b0;

  logic [2:0] reduce_mode;
  mmsr_cmd_t  cmd;
  mmsr_sts_t  sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {29'd0, reduce_mode} : 32'd0;

  // Mode register write
  always_ff @(posedge clk) begin
    if (rst) begin
      reduce_mode <= MODE_HILL;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      reduce_mode <= pwdata[2:0];
    end
  end

  mmsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mmsr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mode          (reduce_mode),
    .signal_value  (signal_value),
    .last_signal   (last_signal),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reduced_value (reduced_value),
    .status        (status)
  );

  // A beat in is always followed by the product step
  a_prod_after_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted during product step");

  // Undefined results read as zero
  a_undef_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_UNDEF)) |-> (reduced_value == 32'sd0))
    else $error("undefined result is not zero");

  // Results are only issued from the done state, never while loading
  a_emit_not_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result issued while accepting signals");

endmodule

`default_nettype wire

@@ rtl/core/mmsr_ram.sv @@
// ----------------------------------------------------------------------------
// mmsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/mmsr_ctrl.sv @@
// ----------------------------------------------------------------------------
// mmsr_ctrl
// Sequencer: loads signals, then runs the selected reduction through
// the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsr_ctrl import mmsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mmsr_sts_t sts,
  output mmsr_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PROD  = 4'd1;
  localparam logic [3:0] S_FIN   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_DEND  = 4'd4;
  localparam logic [3:0] S_MCAND = 4'd5;
  localparam logic [3:0] S_MLOAD = 4'd6;
  localparam logic [3:0] S_MSCAN = 4'd7;
  localparam logic [3:0] S_MEVAL = 4'd8;
  localparam logic [3:0] S_MFIN  = 4'd9;
  localparam logic [3:0] S_GTRY  = 4'd10;
  localparam logic [3:0] S_GMUL  = 4'd11;
  localparam logic [3:0] S_GCMP  = 4'd12;
  localparam logic [3:0] S_GNEXT = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = sts.last_item ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (sts.empty) begin
          state_next = S_DONE;
        end else begin
          case (sts.mode)
            MODE_HILL: state_next = sts.hill_undef ? S_DONE : S_DIV;
            MODE_MEAN: state_next = S_DIV;
            MODE_MED:  state_next = S_MCAND;
            MODE_GEO:  state_next = sts.geo_undef ? S_DONE : S_GTRY;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DEND;
        end
      end
      S_DEND: begin
        cmd.div_end = 1'b1;
        state_next  = S_DONE;
      end
      S_MCAND: begin
        cmd.med_cand = 1'b1;
        state_next   = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.med_load = 1'b1;
        state_next   = S_MSCAN;
      end
      S_MSCAN: begin
        cmd.med_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_MEVAL;
        end
      end
      S_MEVAL: begin
        cmd.med_eval = 1'b1;
        state_next   = sts.i_last ? S_MFIN : S_MCAND;
      end
      S_MFIN: begin
        cmd.med_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_GTRY: begin
        cmd.gm_try = 1'b1;
        state_next = S_GMUL;
      end
      S_GMUL: begin
        if (sts.pass_zero) begin
          state_next = S_GCMP;
        end else begin
          cmd.gm_mul = 1'b1;
        end
      end
      S_GCMP: begin
        cmd.gm_cmp = 1'b1;
        if (sts.limb_last) begin
          state_next = S_GNEXT;
        end
      end
      S_GNEXT: begin
        cmd.gm_next = 1'b1;
        state_next  = sts.bit_zero ? S_DONE : S_GTRY;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mmsr_dp.sv @@
// ----------------------------------------------------------------------------
// mmsr_dp
// Datapath: running statistics, signal store, shared divider, median
// rank scan, limb-serial root search and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsr_dp import mmsr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mmsr_cmd_t          cmd,
  output mmsr_sts_t               sts,
  input  wire logic [2:0]         mode,
  input  wire logic signed [31:0] signal_value,
  input  wire logic               last_signal,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      reduced_value,
  output logic [1:0]              status
);

  // Set state
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic signed [31:0]      prod;
  logic                    prod_sat;
  logic                    zero_seen;
  logic signed [31:0]      largest;
  logic signed [31:0]      smallest;
  logic                    dropped;
  logic                    last_item;
  logic                    prod_pend;
  logic signed [31:0]      xr;

  // Result under construction
  logic signed [31:0] res_value;
  logic               res_sat;
  logic               res_undef;

  // Divider
  logic [NUM_W-1:0]  mag;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic              neg;
  logic              floor_md;
  logic [DCNT_W-1:0] dcnt;

  // Median scan
  logic [IDX_W-1:0]   mi;
  logic [CNT_W-1:0]   mj;
  logic signed [31:0] cand;
  logic [CNT_W-1:0]   lt;
  logic [CNT_W-1:0]   le;
  logic signed [31:0] ma;
  logic signed [31:0] mb;

  // Root search
  logic [31:0]      limb [LIMBS];
  logic [31:0]      carry;
  logic [CNT_W-1:0] pass;
  logic [IDX_W-1:0] li;
  logic [4:0]       gbit;
  logic [30:0]      gy;
  logic             fits;

  logic               full;
  logic signed [31:0] rdata;
  logic [IDX_W-1:0]   raddr;
  logic signed [63:0] pm;
  logic signed [63:0] ps;
  logic [32:0]        psat;
  logic signed [SUM_W:0] hd;
  logic [SUM_W-1:0]   sabs;
  logic [32:0]        ssat;
  logic [DEN_W:0]     rem_sh;
  logic               ge;
  logic [DEN_W:0]     rem_sub;
  logic [NUM_W:0]     qu;
  logic [NUM_W:0]     rnd;
  logic signed [NUM_W:0] qn;
  logic [32:0]        qsat;
  logic [CNT_W-1:0]   cm1;
  logic [CNT_W-1:0]   ka;
  logic [CNT_W-1:0]   kb;
  logic signed [32:0] msum;
  logic [30:0]        trial;
  logic [63:0]        mp;
  logic [CNT_W:0]     wlo;
  logic [CNT_W:0]     lic;
  logic [63:0]        bv;
  logic [31:0]        bnd;
  logic               out_free;

  mmsr_ram #(.WIDTH(32), .DEPTH(MAX_SIGNALS)) u_store (
    .clk   (clk),
    .we    (cmd.load && !full),
    .waddr (count[IDX_W-1:0]),
    .wdata (signal_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full     = (count == CNT_W'(MAX_SIGNALS));
  assign raddr    = cmd.med_cand ? mi : mj[IDX_W-1:0];
  assign out_free = !out_valid || out_ready;

  // Product step, hill denominator, sum magnitude
  assign pm   = prod * xr;
  assign ps   = pm >>> 16;
  assign psat = sat32(ps);
  assign hd   = {sum[SUM_W-1], sum} + (SUM_W + 1)'(Q_ONE);
  assign sabs = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign ssat = sat32(64'(sum));

  // Restoring division step and signed finish
  assign rem_sh  = {rem, mag[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};
  assign qu      = {1'b0, mag};
  assign rnd     = (NUM_W + 1)'(floor_md && (rem != '0));
  assign qn      = neg ? $signed(-qu - rnd) : $signed(qu);
  assign qsat    = sat32(64'(qn));

  // Median ranks
  assign cm1  = count - 1'b1;
  assign ka   = cm1 >> 1;
  assign kb   = count >> 1;
  assign msum = {ma[31], ma} + {mb[31], mb};

  // Root trial, limb multiply, bound limb for y^n <= p * 2^(16(n-1))
  assign trial = gy | (31'd1 << gbit);
  assign mp    = {32'd0, limb[0]} * {33'd0, trial} + {32'd0, carry};
  assign wlo   = {1'b0, cm1 >> 1};
  assign lic   = (CNT_W + 1)'(li);
  assign bv    = {32'd0, (zero_seen ? 32'd0 : prod)} << (cm1[0] ? 16 : 0);
  assign bnd   = (lic == wlo) ? bv[31:0] :
                 (lic == wlo + 1'b1) ? bv[63:32] : 32'd0;

  // Status to controller
  always_comb begin
    sts.last_item  = last_item;
    sts.empty      = (count == '0);
    sts.mode       = mode;
    sts.hill_undef = hd[SUM_W] || (hd == '0);
    sts.geo_undef  = !zero_seen && prod[31];
    sts.div_last   = (dcnt == DCNT_W'(1));
    sts.scan_last  = (mj == count);
    sts.i_last     = (CNT_W'(mi) == cm1);
    sts.pass_zero  = (pass == '0);
    sts.limb_last  = (li == IDX_W'(LIMBS - 1));
    sts.bit_zero   = (gbit == 5'd0);
    sts.out_free   = out_free;
  end

  // Set accumulators: load, product step, clear after a result
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      count     <= '0;
      sum       <= '0;
      prod      <= Q_ONE;
      prod_sat  <= 1'b0;
      zero_seen <= 1'b0;
      largest   <= S32_MIN;
      smallest  <= S32_MAX;
      dropped   <= 1'b0;
      last_item <= 1'b0;
      prod_pend <= 1'b0;
    end else if (cmd.load) begin
      xr        <= signal_value;
      last_item <= last_signal;
      prod_pend <= !full && (signal_value != '0) && !zero_seen;
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
        sum   <= sum + {{(SUM_W - 32){signal_value[31]}}, signal_value};
        if (signal_value > largest) begin
          largest <= signal_value;
        end
        if (signal_value < smallest) begin
          smallest <= signal_value;
        end
        if (signal_value == '0) begin
          zero_seen <= 1'b1;
        end
      end
    end else if (cmd.prod && prod_pend) begin
      prod <= psat[31:0];
      if (psat[32]) begin
        prod_sat <= 1'b1;
      end
    end
  end

  // Reduction engines
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_value <= '0;
      res_sat   <= 1'b0;
      res_undef <= (count == '0);
      neg       <= sum[SUM_W-1];
      rem       <= '0;
      dcnt      <= DCNT_W'(NUM_W);
      mi        <= '0;
      gy        <= '0;
      gbit      <= 5'd30;
      case (mode)
        MODE_HILL: begin
          mag      <= {sabs, 16'd0};
          den      <= hd[DEN_W-1:0];
          floor_md <= 1'b1;
          if (hd[SUM_W] || (hd == '0)) begin
            res_undef <= 1'b1;
          end
        end
        MODE_SUM: begin
          res_value <= ssat[31:0];
          res_sat   <= ssat[32];
        end
        MODE_PROD: begin
          res_value <= zero_seen ? 32'sd0 : prod;
          res_sat   <= !zero_seen && prod_sat;
        end
        MODE_MEAN: begin
          mag      <= NUM_W'(sabs);
          den      <= DEN_W'(count);
          floor_md <= 1'b0;
        end
        MODE_MAX: res_value <= largest;
        MODE_MIN: res_value <= smallest;
        MODE_GEO: begin
          if (!zero_seen && prod[31]) begin
            res_undef <= 1'b1;
          end else begin
            res_sat <= !zero_seen && prod_sat;
          end
        end
        default: begin
          res_value <= '0;
        end
      endcase
    end

    // Shift one quotient bit per cycle
    if (cmd.div_step) begin
      rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      mag  <= {mag[NUM_W-2:0], ge};
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.div_end) begin
      res_value <= qsat[31:0];
      res_sat   <= qsat[32];
    end

    // Rank each stored signal against every stored signal, itself included
    if (cmd.med_cand) begin
      mj <= '0;
      lt <= '0;
      le <= '0;
    end
    if (cmd.med_load) begin
      cand <= rdata;
      mj   <= CNT_W'(1);
    end
    if (cmd.med_step) begin
      if (rdata < cand) begin
        lt <= lt + 1'b1;
      end
      if (rdata <= cand) begin
        le <= le + 1'b1;
      end
      mj <= mj + 1'b1;
    end
    if (cmd.med_eval) begin
      if ((lt <= ka) && (ka < le)) begin
        ma <= cand;
      end
      if ((lt <= kb) && (kb < le)) begin
        mb <= cand;
      end
      mi <= mi + 1'b1;
    end
    if (cmd.med_fin) begin
      res_value <= msum[32:1];
    end

    // Power the trial root limb by limb, then compare against the bound
    if (cmd.gm_try) begin
      for (int k = 1; k < LIMBS; k++) begin
        limb[k] <= '0;
      end
      limb[0] <= {1'b0, trial};
      carry   <= '0;
      pass    <= cm1;
      li      <= '0;
      fits    <= 1'b1;
    end
    if (cmd.gm_mul) begin
      for (int k = 0; k < LIMBS - 1; k++) begin
        limb[k] <= limb[k+1];
      end
      limb[LIMBS-1] <= mp[31:0];
      if (li == IDX_W'(LIMBS - 1)) begin
        li    <= '0;
        pass  <= pass - 1'b1;
        carry <= '0;
      end else begin
        li    <= li + 1'b1;
        carry <= mp[63:32];
      end
    end
    if (cmd.gm_cmp) begin
      for (int k = 0; k < LIMBS - 1; k++) begin
        limb[k] <= limb[k+1];
      end
      limb[LIMBS-1] <= limb[0];
      if (limb[0] != bnd) begin
        fits <= (limb[0] < bnd);
      end
      li <= (li == IDX_W'(LIMBS - 1)) ? '0 : li + 1'b1;
    end
    if (cmd.gm_next) begin
      gy        <= fits ? trial : gy;
      res_value <= {1'b0, (fits ? trial : gy)};
      gbit      <= gbit - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      reduced_value <= res_undef ? 32'sd0 : res_value;
      status        <= dropped ? ST_DROP : res_undef ? ST_UNDEF :
                       res_sat ? ST_SAT : ST_OK;
    end
  end

endmodule

`default_nettype wire
